>>> design/mpfd_pkg.sv
package mpfd_pkg;

	localparam int PANEL_COLUMNS = 128;
	localparam int PANEL_PAGES   = 8;
	localparam int PAGE_BITS     = 8;
	localparam int PANEL_ROWS    = PANEL_PAGES * PAGE_BITS;
	localparam int STORE_BYTES   = PANEL_COLUMNS * PANEL_PAGES;

	localparam int REQ_W     = 3;
	localparam int COORD_W   = 8;
	localparam int BYTE_W    = 8;
	localparam int BIT_IDX_W = $clog2(PAGE_BITS);
	localparam int COL_W     = $clog2(PANEL_COLUMNS);
	localparam int PAGE_W    = (PANEL_PAGES > 1) ? $clog2(PANEL_PAGES) : 1;
	localparam int ADDR_W    = $clog2(STORE_BYTES);
	// one bit over a coordinate so that corner plus extent cannot wrap
	localparam int EXT_W     = COORD_W + 1;

	localparam logic [REQ_W-1:0] REQ_SET_PIXEL = 3'd0;
	localparam logic [REQ_W-1:0] REQ_CLR_PIXEL = 3'd1;
	localparam logic [REQ_W-1:0] REQ_FILL_RECT = 3'd2;
	localparam logic [REQ_W-1:0] REQ_CLR_RECT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FILL_ALL  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_CLR_ALL   = 3'd5;
	localparam logic [REQ_W-1:0] REQ_READ_BYTE = 3'd6;

	typedef logic [REQ_W-1:0]   req_code_t;
	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [BYTE_W-1:0]  byte_t;

	typedef struct packed {
		logic load;
		logic step;
		logic mem_rd;
		logic mem_wr;
		logic wipe_wr;
		logic res_load;
	} mpfd_cmd_t;

	typedef struct packed {
		logic skip;
		logic last;
		logic rd_req;
	} mpfd_sts_t;

endpackage

>>> design/mpfd_req_if.sv
interface mpfd_req_if import mpfd_pkg::*;
();
	logic      valid;
	logic      ready;
	req_code_t req_type;
	coord_t    x_pos;
	coord_t    y_pos;
	coord_t    rect_width;
	coord_t    rect_height;

	modport source (
		output valid, req_type, x_pos, y_pos, rect_width, rect_height,
		input  ready
	);
	modport sink (
		input  valid, req_type, x_pos, y_pos, rect_width, rect_height,
		output ready
	);
endinterface

>>> design/mpfd_rsp_if.sv
interface mpfd_rsp_if import mpfd_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t read_byte;
	logic  clipped;

	modport source (
		output valid, read_byte, clipped,
		input  ready
	);
	modport sink (
		input  valid, read_byte, clipped,
		output ready
	);
endinterface

>>> design/mpfd_ctrl.sv
module mpfd_ctrl import mpfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  req_code_t req_type,
	output logic      out_valid,
	input  logic      out_ready,
	input  mpfd_sts_t sts,
	output mpfd_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_BOOT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_WIPE   = 6'b000100,
		ST_READ   = 6'b001000,
		ST_MODIFY = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		unique case (state_q) inside
			ST_BOOT, ST_WIPE: begin
				cmd.mem_wr  = 1'b1;
				cmd.wipe_wr = 1'b1;
				if (sts.last) begin
					state_d = (state_q == ST_BOOT) ? ST_IDLE : ST_DONE;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (req_type) inside
						REQ_FILL_ALL, REQ_CLR_ALL: state_d = ST_WIPE;
						REQ_SET_PIXEL, REQ_CLR_PIXEL, REQ_FILL_RECT, REQ_CLR_RECT,
						REQ_READ_BYTE: state_d = ST_READ;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				if (sts.skip) begin
					state_d = ST_DONE;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = sts.rd_req ? ST_DONE : ST_MODIFY;
				end
			end
			ST_MODIFY: begin
				cmd.mem_wr = 1'b1;
				if (sts.last) begin
					state_d = ST_DONE;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_DONE: begin
				// hold until the output register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_BOOT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/mpfd_dp.sv
module mpfd_dp import mpfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  mpfd_cmd_t cmd,
	output mpfd_sts_t sts,
	input  req_code_t req_type,
	input  coord_t    x_pos,
	input  coord_t    y_pos,
	input  coord_t    rect_width,
	input  coord_t    rect_height,
	output byte_t     read_byte,
	output logic      clipped
);

	localparam logic [EXT_W-1:0]  COLS_X   = EXT_W'(PANEL_COLUMNS);
	localparam logic [EXT_W-1:0]  ROWS_X   = EXT_W'(PANEL_ROWS);
	localparam logic [COL_W-1:0]  COL_LAST = COL_W'(PANEL_COLUMNS - 1);
	localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(PANEL_PAGES - 1);

	byte_t store_mem [STORE_BYTES];

	logic [PAGE_W-1:0] page_q;
	logic [PAGE_W-1:0] page_hi_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_lo_q;
	logic [COL_W-1:0]  col_hi_q;
	logic              fill_q;
	logic              skip_q;
	logic              clip_q;
	logic              rd_req_q;
	logic              rd_ok_q;
	coord_t            row_lo_q;
	logic [EXT_W-1:0]  row_hi_q;
	byte_t             mem_q;
	byte_t             res_byte_q;
	logic              res_clip_q;

	coord_t            w_eff;
	coord_t            h_eff;
	logic [EXT_W-1:0]  x_ext;
	logic [EXT_W-1:0]  y_ext;
	logic [EXT_W-1:0]  xe;
	logic [EXT_W-1:0]  ye;
	logic [EXT_W-1:0]  xe_cl;
	logic [EXT_W-1:0]  ye_cl;
	logic              zero_ext;
	logic              off_panel;
	logic              empty;
	logic              clip_new;
	logic              is_pixel;
	logic              is_rect;
	logic              is_read;
	logic [ADDR_W-1:0] addr;
	byte_t             mask;
	byte_t             wdata;
	logic [EXT_W-1:0]  row;

	// request decode and rectangle bounds, clamped to the panel
	always_comb begin
		is_pixel  = (req_type == REQ_SET_PIXEL) || (req_type == REQ_CLR_PIXEL);
		is_rect   = (req_type == REQ_FILL_RECT) || (req_type == REQ_CLR_RECT);
		is_read   = (req_type == REQ_READ_BYTE);
		w_eff     = is_pixel ? COORD_W'(1) : rect_width;
		h_eff     = is_pixel ? COORD_W'(1) : rect_height;
		x_ext     = EXT_W'(x_pos);
		y_ext     = EXT_W'(y_pos);
		xe        = x_ext + EXT_W'(w_eff);
		ye        = y_ext + EXT_W'(h_eff);
		zero_ext  = (w_eff == '0) || (h_eff == '0);
		xe_cl     = (xe > COLS_X) ? COLS_X : xe;
		ye_cl     = (ye > ROWS_X) ? ROWS_X : ye;
		off_panel = (x_ext >= COLS_X) || (y_ext >= ROWS_X);
		empty     = zero_ext || (x_ext >= xe_cl) || (y_ext >= ye_cl);
		clip_new  = 1'b0;
		if (is_read) begin
			clip_new = off_panel;
		end else if (is_pixel || is_rect) begin
			clip_new = !zero_ext && ((xe > COLS_X) || (ye > ROWS_X));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q    <= '0;
			page_hi_q <= PAGE_LAST;
			col_q     <= '0;
			col_lo_q  <= '0;
			col_hi_q  <= COL_LAST;
			fill_q    <= 1'b0;
			skip_q    <= 1'b0;
			clip_q    <= 1'b0;
			rd_req_q  <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else if (cmd.load) begin
			clip_q   <= clip_new;
			rd_req_q <= is_read;
			rd_ok_q  <= is_read && !off_panel;
			unique case (req_type) inside
				REQ_FILL_ALL, REQ_CLR_ALL: begin
					page_q    <= '0;
					page_hi_q <= PAGE_LAST;
					col_q     <= '0;
					col_lo_q  <= '0;
					col_hi_q  <= COL_LAST;
					fill_q    <= (req_type == REQ_FILL_ALL);
					skip_q    <= 1'b0;
				end
				default: begin
					page_q    <= PAGE_W'(y_pos >> BIT_IDX_W);
					page_hi_q <= PAGE_W'((ye_cl - EXT_W'(1)) >> BIT_IDX_W);
					col_q     <= COL_W'(x_pos);
					col_lo_q  <= COL_W'(x_pos);
					col_hi_q  <= COL_W'(xe_cl - EXT_W'(1));
					fill_q    <= (req_type == REQ_SET_PIXEL) || (req_type == REQ_FILL_RECT);
					skip_q    <= is_read ? off_panel : empty;
				end
			endcase
		end else if (cmd.step) begin
			// advance column-first, wrap to the rectangle's left column on the next page
			if (col_q == col_hi_q) begin
				col_q  <= col_lo_q;
				page_q <= page_q + PAGE_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_lo_q <= y_pos;
			row_hi_q <= ye_cl;
		end
		if (cmd.res_load) begin
			res_byte_q <= rd_ok_q ? mem_q : '0;
			res_clip_q <= clip_q;
		end
	end

	// rows of the current page that fall inside the rectangle
	always_comb begin
		mask = '0;
		row  = '0;
		for (int b = 0; b < PAGE_BITS; b++) begin
			row     = (EXT_W'(page_q) << BIT_IDX_W) | EXT_W'(b);
			mask[b] = (row >= EXT_W'(row_lo_q)) && (row < row_hi_q);
		end
	end

	assign addr  = ADDR_W'(page_q) * ADDR_W'(PANEL_COLUMNS) + ADDR_W'(col_q);
	assign wdata = cmd.wipe_wr ? {BYTE_W{fill_q}} :
	               (fill_q ? (mem_q | mask) : (mem_q & ~mask));

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			store_mem[addr] <= wdata;
		end
		if (cmd.mem_rd) begin
			mem_q <= store_mem[addr];
		end
	end

	assign sts.skip   = skip_q;
	assign sts.last   = (col_q == col_hi_q) && (page_q == page_hi_q);
	assign sts.rd_req = rd_req_q;

	assign read_byte = res_byte_q;
	assign clipped   = res_clip_q;

endmodule

>>> design/mono_page_framebuffer_draw.sv
// Monochrome page framebuffer, PANEL_COLUMNS x 8*PANEL_PAGES pixels (128x64), kept in a
// single-port memory of PANEL_COLUMNS*PANEL_PAGES bytes; pixel (x,y) is bit y%8 of byte
// (y/8)*PANEL_COLUMNS+x. After reset the block clears the store with req.ready low.
// Every request gives one response, held in an output register so the next request is
// taken while it waits. Work per request is set by the read-modify-write through the one
// memory port: a read byte request reads its byte once; a pixel or rectangle reads and
// writes back each page byte it touches (a rectangle that touches nothing, or an
// off-panel pixel or read, touches no byte); fill or clear all writes every byte.
// Off-panel pixels are skipped and flag clipped; read_byte is zero for all but an on-panel read.
module mono_page_framebuffer_draw import mpfd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	mpfd_req_if.sink    req,
	mpfd_rsp_if.source  rsp
);

	mpfd_cmd_t cmd;
	mpfd_sts_t sts;

	mpfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.req_type  (req.req_type),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpfd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.x_pos       (req.x_pos),
		.y_pos       (req.y_pos),
		.rect_width  (req.rect_width),
		.rect_height (req.rect_height),
		.read_byte   (rsp.read_byte),
		.clipped     (rsp.clipped)
	);

endmodule

>>> design/mpfd_check.sv
module mpfd_check import mpfd_pkg::*;
(
	input logic  clk,
	input logic  arst_n,
	input logic  req_valid,
	input logic  req_ready,
	input logic  rsp_valid,
	input logic  rsp_ready,
	input byte_t read_byte,
	input logic  clipped
);

	// a stalled response keeps its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(clipped))
		else $error("response changed while stalled");

	// a clipped result never carries store data
	a_clip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && clipped |-> read_byte == '0)
		else $error("clipped response with nonzero byte");

	// one request at a time: taking a request drops ready for the next cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

endmodule

bind mono_page_framebuffer_draw mpfd_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.read_byte (rsp.read_byte),
	.clipped   (rsp.clipped)
);

>>> tb/sv/mpfd_reply_checker.sv
module mpfd_reply_checker import mpfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	mpfd_req_if  req_mon,
	mpfd_rsp_if  rsp_mon,
	output int   errors,
	output int   pending
);

	typedef struct packed {
		byte_t read_byte;
		logic  clipped;
	} reply_t;

	// local image of the panel, page-major like the block's store
	byte_t  frame [STORE_BYTES];
	reply_t due_replies [$];
	reply_t want;
	int     err_count = 0;
	int     reply_idx = 0;

	task automatic report(string msg);
		if (err_count < 20)
			$display("mismatch at reply %0d: %s", reply_idx, msg);
		err_count++;
	endtask

	// caller guarantees (x,y) lies on the panel
	function automatic void paint(int x, int y, bit on);
		int    addr;
		byte_t mask;
		addr = (y / PAGE_BITS) * PANEL_COLUMNS + x;
		mask = byte_t'(1) << (y % PAGE_BITS);
		if (on)
			frame[addr] = frame[addr] | mask;
		else
			frame[addr] = frame[addr] & ~mask;
	endfunction

	function automatic reply_t draw_and_answer(req_code_t op, coord_t x, coord_t y,
			coord_t w, coord_t h);
		reply_t r;
		int     xi;
		int     yi;
		int     xe;
		int     ye;
		bit     off;
		r   = '0;
		xi  = int'(x);
		yi  = int'(y);
		off = (xi >= PANEL_COLUMNS) || (yi >= PANEL_ROWS);
		case (op)
			REQ_SET_PIXEL, REQ_CLR_PIXEL: begin
				r.clipped = off;
				if (!off)
					paint(xi, yi, op == REQ_SET_PIXEL);
			end
			REQ_FILL_RECT, REQ_CLR_RECT: begin
				// empty rectangle: no pixels, no clip
				if (w != 0 && h != 0) begin
					xe = xi + int'(w);
					ye = yi + int'(h);
					r.clipped = (xe > PANEL_COLUMNS) || (ye > PANEL_ROWS);
					if (xe > PANEL_COLUMNS)
						xe = PANEL_COLUMNS;
					if (ye > PANEL_ROWS)
						ye = PANEL_ROWS;
					for (int row = yi; row < ye; row++)
						for (int col = xi; col < xe; col++)
							paint(col, row, op == REQ_FILL_RECT);
				end
			end
			REQ_FILL_ALL: begin
				foreach (frame[i])
					frame[i] = '1;
			end
			REQ_CLR_ALL: begin
				foreach (frame[i])
					frame[i] = '0;
			end
			REQ_READ_BYTE: begin
				r.clipped = off;
				if (!off)
					r.read_byte = frame[(yi / PAGE_BITS) * PANEL_COLUMNS + xi];
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (frame[i])
				frame[i] = '0;
			due_replies.delete();
		end else begin
			// check the reply first: it always belongs to an older request
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (due_replies.size() == 0) begin
					report($sformatf("reply with nothing outstanding (read_byte %0h clipped %0b)",
						rsp_mon.read_byte, rsp_mon.clipped));
				end else begin
					want = due_replies.pop_front();
					if (rsp_mon.read_byte !== want.read_byte)
						report($sformatf("read_byte got %0h want %0h",
							rsp_mon.read_byte, want.read_byte));
					if (rsp_mon.clipped !== want.clipped)
						report($sformatf("clipped got %0b want %0b",
							rsp_mon.clipped, want.clipped));
				end
				reply_idx++;
			end
			if (req_mon.valid && req_mon.ready)
				due_replies.push_back(draw_and_answer(req_mon.req_type, req_mon.x_pos,
					req_mon.y_pos, req_mon.rect_width, req_mon.rect_height));
		end
		pending <= due_replies.size();
		errors  <= err_count;
	end

endmodule

>>> tb/sv/tb.sv
module tb;
	import mpfd_pkg::*;

	localparam req_code_t REQ_UNUSED       = 3'd7;
	localparam int        RANDOM_PER_PHASE = 450;
	localparam int        HOLD_CYCLES      = 300;
	localparam int        DRAIN_CYCLES     = 40;
	// clearing pass, full-store sweeps and large rectangles under stalls, many times over
	localparam int        CYCLE_LIMIT      = 2_000_000;

	logic clk;
	logic arst_n;

	mpfd_req_if req ();
	mpfd_rsp_if rsp ();

	int   errors;
	int   pending;
	int   snd_idle_pct  = 0;
	int   rcv_stall_pct = 0;
	logic rsp_hold      = 1'b0;
	event hold_evt;
	int   cycle_count   = 0;
	int   n_pixel       = 0;
	int   n_rect        = 0;
	int   n_full        = 0;
	int   n_read        = 0;
	int   n_unused      = 0;

	mono_page_framebuffer_draw u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	mpfd_reply_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_mon (req),
		.rsp_mon (rsp),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count, pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= !rsp_hold && ($urandom_range(99) >= rcv_stall_pct);
		end
	end

	// long reply hold-off so the block fills up and stalls its request side
	initial forever begin
		@(hold_evt);
		rsp_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rsp_hold <= 1'b0;
	end

	task automatic set_idle(int snd, int rcv);
		snd_idle_pct  <= snd;
		rcv_stall_pct <= rcv;
	endtask

	task automatic send_req(req_code_t op, coord_t x, coord_t y, coord_t w, coord_t h);
		while ($urandom_range(99) < snd_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid       <= 1'b1;
		req.req_type    <= op;
		req.x_pos       <= x;
		req.y_pos       <= y;
		req.rect_width  <= w;
		req.rect_height <= h;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		case (op)
			REQ_SET_PIXEL, REQ_CLR_PIXEL: n_pixel++;
			REQ_FILL_RECT, REQ_CLR_RECT:  n_rect++;
			REQ_FILL_ALL, REQ_CLR_ALL:    n_full++;
			REQ_READ_BYTE:                n_read++;
			default:                      n_unused++;
		endcase
	endtask

	// mostly on the panel, now and then anywhere in the field's range
	function automatic coord_t pick_coord(int span);
		if ($urandom_range(99) < 15)
			return coord_t'($urandom_range(255));
		return coord_t'($urandom_range(span - 1));
	endfunction

	// keep rectangles small except for a few large sweeps
	function automatic coord_t pick_extent();
		if ($urandom_range(99) < 6)
			return coord_t'($urandom_range(255));
		return coord_t'($urandom_range(16));
	endfunction

	task automatic send_random(int count);
		int        roll;
		req_code_t op;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 22)
				op = REQ_SET_PIXEL;
			else if (roll < 36)
				op = REQ_CLR_PIXEL;
			else if (roll < 50)
				op = REQ_FILL_RECT;
			else if (roll < 62)
				op = REQ_CLR_RECT;
			else if (roll < 64)
				op = REQ_FILL_ALL;
			else if (roll < 66)
				op = REQ_CLR_ALL;
			else if (roll < 68)
				op = REQ_UNUSED;
			else
				op = REQ_READ_BYTE;
			send_req(op, pick_coord(PANEL_COLUMNS), pick_coord(PANEL_ROWS),
				pick_extent(), pick_extent());
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		req.valid       = 1'b0;
		req.req_type    = REQ_SET_PIXEL;
		req.x_pos       = '0;
		req.y_pos       = '0;
		req.rect_width  = '0;
		req.rect_height = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: corners, off-panel pixels and reads, empty and clipped rectangles
		send_req(REQ_READ_BYTE, 8'd0,   8'd0,   8'd0,   8'd0);
		send_req(REQ_SET_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0);
		send_req(REQ_SET_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0);
		send_req(REQ_READ_BYTE, 8'd127, 8'd56,  8'd0,   8'd0);
		send_req(REQ_SET_PIXEL, 8'd128, 8'd0,   8'd0,   8'd0);
		send_req(REQ_SET_PIXEL, 8'd0,   8'd64,  8'd0,   8'd0);
		send_req(REQ_SET_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255);
		send_req(REQ_CLR_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0);
		send_req(REQ_CLR_PIXEL, 8'd200, 8'd10,  8'd0,   8'd0);
		send_req(REQ_FILL_RECT, 8'd10,  8'd5,   8'd20,  8'd12);
		send_req(REQ_READ_BYTE, 8'd15,  8'd8,   8'd0,   8'd0);
		send_req(REQ_FILL_RECT, 8'd5,   8'd5,   8'd0,   8'd10);
		send_req(REQ_FILL_RECT, 8'd200, 8'd200, 8'd10,  8'd0);
		send_req(REQ_FILL_RECT, 8'd120, 8'd60,  8'd20,  8'd10);
		send_req(REQ_FILL_RECT, 8'd255, 8'd255, 8'd255, 8'd255);
		send_req(REQ_CLR_RECT,  8'd12,  8'd6,   8'd4,   8'd4);
		send_req(REQ_READ_BYTE, 8'd12,  8'd0,   8'd0,   8'd0);
		send_req(REQ_CLR_RECT,  8'd0,   8'd0,   8'd255, 8'd255);
		send_req(REQ_FILL_ALL,  8'd0,   8'd0,   8'd0,   8'd0);
		send_req(REQ_READ_BYTE, 8'd64,  8'd32,  8'd0,   8'd0);
		send_req(REQ_READ_BYTE, 8'd128, 8'd0,   8'd0,   8'd0);
		send_req(REQ_READ_BYTE, 8'd0,   8'd64,  8'd0,   8'd0);
		send_req(REQ_CLR_PIXEL, 8'd3,   8'd3,   8'd0,   8'd0);
		send_req(REQ_CLR_ALL,   8'd0,   8'd0,   8'd0,   8'd0);
		send_req(REQ_UNUSED,    8'd77,  8'd21,  8'd9,   8'd9);

		// keep offering pixel requests while replies are held off
		-> hold_evt;
		repeat (8)
			send_req(REQ_SET_PIXEL, coord_t'($urandom_range(127)),
				coord_t'($urandom_range(63)), 8'd0, 8'd0);
		send_random(RANDOM_PER_PHASE);

		set_idle(82, 0);
		send_random(RANDOM_PER_PHASE);
		set_idle(0, 82);
		send_random(RANDOM_PER_PHASE);
		set_idle(12, 12);
		send_random(RANDOM_PER_PHASE);

		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d pixel writes, %0d rectangles, %0d whole-store, %0d reads, %0d unused codes",
			n_pixel + n_rect + n_full + n_read + n_unused, n_pixel, n_rect, n_full, n_read,
			n_unused);
		$display("Traffic ran without gaps, with 82%% request gaps, 82%% reply stalls, 12%% of both, and one %0d-cycle reply hold-off",
			HOLD_CYCLES);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
